// File: rtl/dcf_pkg.sv
package dcf_pkg;

	// Fixed field widths of the ports
	localparam int NODE_W = 6;
	localparam int CFG_W  = 7;
	localparam int EDGE_W = 64;

	// Visit mark codes
	localparam logic [1:0] MARK_FREE = 2'd0;
	localparam logic [1:0] MARK_PATH = 2'd1;
	localparam logic [1:0] MARK_DONE = 2'd2;

	// One mark entry: visit code and the stack level of a node on the path
	typedef struct packed {
		logic [1:0]        code;
		logic [NODE_W-1:0] lvl;
	} mark_t;

	// Write request into a RAM that holds marks
	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] addr;
		mark_t             data;
	} mark_wr_t;

endpackage

// File: rtl/dcf_adj_ram.sv
module dcf_adj_ram
	import dcf_pkg::*;
#(
	parameter int N     = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [N-1:0]     wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [N-1:0]     rdata
);

	logic [N-1:0] mem [N];
	logic [N-1:0] rdata_q;

	// Write one row, read one row with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/dcf_mark_ram.sv
module dcf_mark_ram
	import dcf_pkg::*;
#(
	parameter int N     = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  mark_wr_t         wr,
	input  logic [IDX_W-1:0] raddr,
	output mark_t            rdata
);

	mark_t        mem [N];
	mark_t        rdata_q;
	logic [N-1:0] valid_q;
	logic         rvalid_q;

	// Store mark data
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr[IDX_W-1:0]] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	// Track written entries; drop all of them at a new search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[raddr];
			if (clr) begin
				valid_q <= '0;
			end else if (wr.we) begin
				valid_q[wr.addr[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	// Unwritten entries read as unvisited
	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// File: rtl/dcf_stack_ram.sv
module dcf_stack_ram
	import dcf_pkg::*;
#(
	parameter int N     = 64,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [IDX_W-1:0] wnode,
	input  logic [CNT_W-1:0] wcur,
	input  logic [IDX_W-1:0] raddr,
	output logic [IDX_W-1:0] rnode,
	output logic [CNT_W-1:0] rcur
);

	logic [IDX_W+CNT_W-1:0] mem [N];
	logic [IDX_W+CNT_W-1:0] rdata_q;

	// Save node and cursor of a level, read one level back
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wnode, wcur};
		end
		rdata_q <= mem[raddr];
	end

	assign rnode = rdata_q[IDX_W+CNT_W-1:CNT_W];
	assign rcur  = rdata_q[CNT_W-1:0];

endmodule

// File: rtl/dcf_ctrl.sv
module dcf_ctrl
	import dcf_pkg::*;
#(
	parameter int N     = 64,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	// command
	input  logic              start,
	output logic              busy,
	input  logic [NODE_W-1:0] row_index,
	input  logic              last_row,
	// configuration
	input  logic              cfg_valid,
	input  logic [CFG_W-1:0]  cfg_data,
	// results
	output logic              result_valid,
	output logic [NODE_W-1:0] node_id,
	output logic              acyclic,
	output logic              last_of_run,
	// adjacency RAM
	output logic              adj_we,
	output logic [IDX_W-1:0]  adj_waddr,
	output logic [IDX_W-1:0]  adj_raddr,
	input  logic [N-1:0]      adj_rdata,
	// mark RAM
	output logic              mark_clr,
	output mark_wr_t          mark_wr,
	output logic [IDX_W-1:0]  mark_raddr,
	input  mark_t             mark_rdata,
	// stack RAM
	output logic              stk_we,
	output logic [IDX_W-1:0]  stk_waddr,
	output logic [IDX_W-1:0]  stk_wnode,
	output logic [CNT_W-1:0]  stk_wcur,
	output logic [IDX_W-1:0]  stk_raddr,
	input  logic [IDX_W-1:0]  stk_rnode,
	input  logic [CNT_W-1:0]  stk_rcur
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ROOT   = 4'd1;
	localparam logic [3:0] S_ROOT_W = 4'd2;
	localparam logic [3:0] S_STEP   = 4'd3;
	localparam logic [3:0] S_EDGE_W = 4'd4;
	localparam logic [3:0] S_POP_W  = 4'd5;
	localparam logic [3:0] S_POP_R  = 4'd6;
	localparam logic [3:0] S_EMIT   = 4'd7;
	localparam logic [3:0] S_EMIT_W = 4'd8;

	logic [3:0]        state_q, state_d;
	logic [CFG_W-1:0]  ncfg_q;
	logic [CNT_W-1:0]  n_q, n_d;
	logic [CNT_W-1:0]  root_q, root_d;
	logic [IDX_W-1:0]  top_q, top_d;
	logic [CNT_W-1:0]  cur_q, cur_d;
	logic [N-1:0]      row_q, row_d;
	logic [CNT_W-1:0]  depth_q, depth_d;
	logic [IDX_W-1:0]  tgt_q, tgt_d;
	logic [CNT_W-1:0]  lvl_q, lvl_d;
	logic              res_vld_q, res_vld_d;
	logic [NODE_W-1:0] res_node_q, res_node_d;
	logic              res_acyc_q, res_acyc_d;
	logic              res_last_q, res_last_d;
	logic [CNT_W-1:0]  cur_dec;
	logic [CNT_W-1:0]  n_sat;
	logic              row_in_range;

	assign cur_dec      = cur_q - CNT_W'(1);
	assign n_sat        = (ncfg_q > CFG_W'(N)) ? CNT_W'(N) : CNT_W'(ncfg_q);
	assign row_in_range = (CFG_W'(row_index) < CFG_W'(N));

	// Search FSM: one cursor step per cycle in S_STEP, registered RAM reads
	always_comb begin
		state_d    = state_q;
		n_d        = n_q;
		root_d     = root_q;
		top_d      = top_q;
		cur_d      = cur_q;
		row_d      = row_q;
		depth_d    = depth_q;
		tgt_d      = tgt_q;
		lvl_d      = lvl_q;
		res_vld_d  = 1'b0;
		res_node_d = res_node_q;
		res_acyc_d = res_acyc_q;
		res_last_d = res_last_q;
		adj_we     = 1'b0;
		adj_waddr  = row_index[IDX_W-1:0];
		adj_raddr  = '0;
		mark_clr   = 1'b0;
		mark_wr    = '0;
		mark_raddr = '0;
		stk_we     = 1'b0;
		stk_waddr  = '0;
		stk_wnode  = top_q;
		stk_wcur   = cur_q;
		stk_raddr  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					adj_we = row_in_range;
					if (last_row) begin
						n_d      = n_sat;
						mark_clr = 1'b1;
						root_d   = '0;
						depth_d  = '0;
						state_d  = S_ROOT;
					end
				end
			end
			S_ROOT: begin
				if (root_q == n_q) begin
					// no cycle anywhere
					res_vld_d  = 1'b1;
					res_node_d = '0;
					res_acyc_d = 1'b1;
					res_last_d = 1'b1;
					state_d    = S_IDLE;
				end else begin
					mark_raddr = root_q[IDX_W-1:0];
					adj_raddr  = root_q[IDX_W-1:0];
					state_d    = S_ROOT_W;
				end
			end
			S_ROOT_W: begin
				if (mark_rdata.code != MARK_FREE) begin
					root_d  = root_q + CNT_W'(1);
					state_d = S_ROOT;
				end else begin
					top_d             = root_q[IDX_W-1:0];
					cur_d             = n_q;
					row_d             = adj_rdata;
					depth_d           = CNT_W'(1);
					mark_wr.we        = 1'b1;
					mark_wr.addr      = NODE_W'(root_q[IDX_W-1:0]);
					mark_wr.data.code = MARK_PATH;
					mark_wr.data.lvl  = '0;
					state_d           = S_STEP;
				end
			end
			S_STEP: begin
				if (cur_q == '0) begin
					// all neighbors tried: retire the top node
					mark_wr.we        = 1'b1;
					mark_wr.addr      = NODE_W'(top_q);
					mark_wr.data.code = MARK_DONE;
					mark_wr.data.lvl  = '0;
					depth_d           = depth_q - CNT_W'(1);
					if (depth_q == CNT_W'(1)) begin
						root_d  = root_q + CNT_W'(1);
						state_d = S_ROOT;
					end else begin
						stk_raddr = IDX_W'(depth_q - CNT_W'(2));
						state_d   = S_POP_W;
					end
				end else begin
					cur_d = cur_dec;
					if (row_q[cur_dec[IDX_W-1:0]]) begin
						tgt_d      = cur_dec[IDX_W-1:0];
						mark_raddr = cur_dec[IDX_W-1:0];
						adj_raddr  = cur_dec[IDX_W-1:0];
						state_d    = S_EDGE_W;
					end
				end
			end
			S_EDGE_W: begin
				case (mark_rdata.code)
					MARK_FREE: begin
						// descend: save the current top, make the target the top
						stk_we            = 1'b1;
						stk_waddr         = IDX_W'(depth_q - CNT_W'(1));
						top_d             = tgt_q;
						cur_d             = n_q;
						row_d             = adj_rdata;
						mark_wr.we        = 1'b1;
						mark_wr.addr      = NODE_W'(tgt_q);
						mark_wr.data.code = MARK_PATH;
						mark_wr.data.lvl  = NODE_W'(depth_q);
						depth_d           = depth_q + CNT_W'(1);
						state_d           = S_STEP;
					end
					MARK_PATH: begin
						// back edge: emit the path from the target's level
						lvl_d   = CNT_W'(mark_rdata.lvl);
						state_d = S_EMIT;
					end
					default: begin
						state_d = S_STEP;
					end
				endcase
			end
			S_POP_W: begin
				top_d     = stk_rnode;
				cur_d     = stk_rcur;
				adj_raddr = stk_rnode;
				state_d   = S_POP_R;
			end
			S_POP_R: begin
				row_d   = adj_rdata;
				state_d = S_STEP;
			end
			S_EMIT: begin
				if (lvl_q == depth_q - CNT_W'(1)) begin
					res_vld_d  = 1'b1;
					res_node_d = NODE_W'(top_q);
					res_acyc_d = 1'b0;
					res_last_d = 1'b1;
					state_d    = S_IDLE;
				end else begin
					stk_raddr = lvl_q[IDX_W-1:0];
					state_d   = S_EMIT_W;
				end
			end
			S_EMIT_W: begin
				res_vld_d  = 1'b1;
				res_node_d = NODE_W'(stk_rnode);
				res_acyc_d = 1'b0;
				res_last_d = 1'b0;
				lvl_d      = lvl_q + CNT_W'(1);
				state_d    = S_EMIT;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ncfg_q    <= CFG_W'(1);
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_vld_q <= res_vld_d;
			if (cfg_valid) begin
				ncfg_q <= cfg_data;
			end
		end
	end

	// Search payload registers
	always_ff @(posedge clk) begin
		n_q        <= n_d;
		root_q     <= root_d;
		top_q      <= top_d;
		cur_q      <= cur_d;
		row_q      <= row_d;
		depth_q    <= depth_d;
		tgt_q      <= tgt_d;
		lvl_q      <= lvl_d;
		res_node_q <= res_node_d;
		res_acyc_q <= res_acyc_d;
		res_last_q <= res_last_d;
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_vld_q;
	assign node_id      = res_node_q;
	assign acyclic      = res_acyc_q;
	assign last_of_run  = res_last_q;

endmodule

// File: rtl/directed_cycle_finder_top.sv
// Row load: one row per cycle while idle; an item without the last-row mark keeps it idle.
// Search: n+1 cursor steps per node; each edge hit adds S_EDGE_W, each root S_ROOT and
// S_ROOT_W, each pop S_POP_W and S_POP_R.
// Cycle output: one stack RAM read per node (S_EMIT_W), none for the last node (the top);
// the acyclic result needs no read. Each result strobes result_valid once; no stall.
// Reset (arst_n low) idles the sequencer, sets node_count to 1 and marks all nodes unvisited.
module directed_cycle_finder_top
	import dcf_pkg::*;
#(
	parameter int MAX_NODE_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [NODE_W-1:0] row_index,
	input  logic [EDGE_W-1:0] row_edges,
	input  logic              last_row,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              result_valid,
	output logic [NODE_W-1:0] node_id,
	output logic              acyclic,
	output logic              last_of_run
);

	localparam int IDX_W = $clog2(MAX_NODE_COUNT);
	localparam int CNT_W = $clog2(MAX_NODE_COUNT + 1);

	logic                      adj_we;
	logic [IDX_W-1:0]          adj_waddr;
	logic [IDX_W-1:0]          adj_raddr;
	logic [MAX_NODE_COUNT-1:0] adj_rdata;
	logic                      mark_clr;
	mark_wr_t                  mark_wr;
	logic [IDX_W-1:0]          mark_raddr;
	mark_t                     mark_rdata;
	logic                      stk_we;
	logic [IDX_W-1:0]          stk_waddr;
	logic [IDX_W-1:0]          stk_wnode;
	logic [CNT_W-1:0]          stk_wcur;
	logic [IDX_W-1:0]          stk_raddr;
	logic [IDX_W-1:0]          stk_rnode;
	logic [CNT_W-1:0]          stk_rcur;

	// Configuration writes are taken at any time
	assign cfg_ready = 1'b1;

	dcf_ctrl #(
		.N     (MAX_NODE_COUNT),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.row_index    (row_index),
		.last_row     (last_row),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.node_id      (node_id),
		.acyclic      (acyclic),
		.last_of_run  (last_of_run),
		.adj_we       (adj_we),
		.adj_waddr    (adj_waddr),
		.adj_raddr    (adj_raddr),
		.adj_rdata    (adj_rdata),
		.mark_clr     (mark_clr),
		.mark_wr      (mark_wr),
		.mark_raddr   (mark_raddr),
		.mark_rdata   (mark_rdata),
		.stk_we       (stk_we),
		.stk_waddr    (stk_waddr),
		.stk_wnode    (stk_wnode),
		.stk_wcur     (stk_wcur),
		.stk_raddr    (stk_raddr),
		.stk_rnode    (stk_rnode),
		.stk_rcur     (stk_rcur)
	);

	dcf_adj_ram #(
		.N     (MAX_NODE_COUNT),
		.IDX_W (IDX_W)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (row_edges[MAX_NODE_COUNT-1:0]),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	dcf_mark_ram #(
		.N     (MAX_NODE_COUNT),
		.IDX_W (IDX_W)
	) u_mark_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mark_clr),
		.wr     (mark_wr),
		.raddr  (mark_raddr),
		.rdata  (mark_rdata)
	);

	dcf_stack_ram #(
		.N     (MAX_NODE_COUNT),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wnode (stk_wnode),
		.wcur  (stk_wcur),
		.raddr (stk_raddr),
		.rnode (stk_rnode),
		.rcur  (stk_rcur)
	);

endmodule

// File: verif/tb_directed_cycle_finder_top.sv
`timescale 1ns / 1ps

module tb_directed_cycle_finder_top;
	import dcf_pkg::*;

	localparam int NODE_SLOTS    = 64;
	localparam int ITEM_TARGET   = 104;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 2000000;

	typedef struct packed {
		logic [NODE_W-1:0] idx;
		logic [EDGE_W-1:0] edges;
		logic              ends_graph;
	} row_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              acyc;
		logic              tail;
	} cycle_node_t;

	typedef enum int {
		SHAPE_SPARSE,
		SHAPE_DENSE,
		SHAPE_DAG,
		SHAPE_DAG_BACK,
		SHAPE_RING,
		SHAPE_SELF_LOOP
	} graph_shape_e;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [NODE_W-1:0] row_index = '0;
	logic [EDGE_W-1:0] row_edges = '0;
	logic              last_row = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              result_valid;
	logic [NODE_W-1:0] node_id;
	logic              acyclic;
	logic              last_of_run;

	// Predictor copy of the graph and the node count register
	logic [EDGE_W-1:0] adj_mem [NODE_SLOTS];
	logic [CFG_W-1:0]  count_shadow = 7'd1;
	bit   [63:0]       row_loaded = '0;

	row_item_t   row_feed_q [$];
	cycle_node_t cycle_expect_q [$];
	row_item_t   next_row;
	cycle_node_t want;

	int node_order [NODE_SLOTS];
	int queued_rows = 0;
	int row_transfers = 0;
	int search_count = 0;
	int result_count = 0;
	int acyclic_runs = 0;
	int cyclic_runs = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;

	directed_cycle_finder_top #(
		.MAX_NODE_COUNT(NODE_SLOTS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.row_index    (row_index),
		.row_edges    (row_edges),
		.last_row     (last_row),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.node_id      (node_id),
		.acyclic      (acyclic),
		.last_of_run  (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [EDGE_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Counts above the node limit saturate
	function automatic int active_count(input logic [CFG_W-1:0] value);
		return (value > 7'd64) ? NODE_SLOTS : int'(value);
	endfunction

	function automatic logic [EDGE_W-1:0] count_mask(input int n);
		return (n >= NODE_SLOTS) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	// Walk the graph depth first and queue the first cycle found, or the acyclic result
	function automatic void trace_first_cycle();
		logic [1:0]        mark [NODE_SLOTS];
		logic [NODE_W-1:0] path [NODE_SLOTS];
		int                cursor [NODE_SLOTS];
		logic [EDGE_W-1:0] cols;
		int                n, depth, top, c, first;
		n = active_count(count_shadow);
		cols = count_mask(n);
		for (int i = 0; i < NODE_SLOTS; i++)
			mark[i] = MARK_FREE;
		for (int root = 0; root < n; root++) begin
			if (mark[root] == MARK_FREE) begin
				mark[root] = MARK_PATH;
				path[0] = NODE_W'(root);
				cursor[0] = n;
				depth = 1;
				while (depth > 0) begin
					top = int'(path[depth-1]);
					c = cursor[depth-1];
					if (c == 0) begin
						// all neighbors tried: retire the node
						mark[top] = MARK_DONE;
						depth--;
					end else begin
						// neighbors go from the highest index down
						c--;
						cursor[depth-1] = c;
						if (adj_mem[top][c] && cols[c]) begin
							if (mark[c] == MARK_FREE) begin
								mark[c] = MARK_PATH;
								path[depth] = NODE_W'(c);
								cursor[depth] = n;
								depth++;
							end else if (mark[c] == MARK_PATH) begin
								// back edge: emit the path from the reached node to the top
								first = 0;
								while (int'(path[first]) != c)
									first++;
								for (int i = first; i < depth; i++)
									cycle_expect_q.push_back('{node: path[i], acyc: 1'b0,
										tail: (i == depth - 1)});
								return;
							end
						end
					end
				end
			end
		end
		cycle_expect_q.push_back('{node: '0, acyc: 1'b1, tail: 1'b1});
	endfunction

	task automatic queue_row(input int idx, input logic [EDGE_W-1:0] edges, input bit ends);
		row_feed_q.push_back('{idx: NODE_W'(idx), edges: edges, ends_graph: ends});
		row_loaded[idx] = 1'b1;
		queued_rows++;
	endtask

	task automatic shuffle_order(input int n);
		int j, tmp;
		for (int i = 0; i < n; i++)
			node_order[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = node_order[i];
			node_order[i] = node_order[j];
			node_order[j] = tmp;
		end
	endtask

	task automatic write_node_count(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_shadow = value;
	endtask

	// Hold until every row is sent and every result is back, then let the block settle
	task automatic wait_idle();
		do @(negedge clk); while (row_feed_q.size() != 0 || start || cycle_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: send rows in bursts with random gaps; predict on each accepted transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			row_index <= '0;
			row_edges <= '0;
			last_row <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				adj_mem[row_index] = row_edges;
				row_transfers++;
				if (last_row) begin
					search_count++;
					trace_first_cycle();
				end
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (row_feed_q.size() != 0) begin
					next_row = row_feed_q.pop_front();
					start <= 1'b1;
					row_index <= next_row.idx;
					row_edges <= next_row.edges;
					last_row <= next_row.ends_graph;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 10);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			result_count++;
			if (cycle_expect_q.size() == 0) begin
				$error("unexpected result: node_id %0d acyclic %0b last_of_run %0b",
					node_id, acyclic, last_of_run);
				fail_count++;
			end else begin
				want = cycle_expect_q.pop_front();
				if (node_id !== want.node) begin
					$error("node_id mismatch: expected %0d, actual %0d", want.node, node_id);
					fail_count++;
				end
				if (acyclic !== want.acyc) begin
					$error("acyclic mismatch: expected %0b, actual %0b", want.acyc, acyclic);
					fail_count++;
				end
				if (last_of_run !== want.tail) begin
					$error("last_of_run mismatch: expected %0b, actual %0b",
						want.tail, last_of_run);
					fail_count++;
				end
				if (want.tail) begin
					if (want.acyc)
						acyclic_runs++;
					else
						cyclic_runs++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding", cycle_count,
				cycle_expect_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [EDGE_W-1:0] fresh_rows [NODE_SLOTS];
		logic [CFG_W-1:0]  pick;
		graph_shape_e      shape;
		int                n, lo, hi, cnt, phase_no;
		bit                patch, tail_row;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Single node: no edge, self loop, edges only beyond the count
		write_node_count(7'd1);
		queue_row(0, '0, 1'b1);
		queue_row(0, 64'h1, 1'b1);
		queue_row(0, ~64'h1, 1'b1);
		wait_idle();

		// Empty graph
		write_node_count(7'd0);
		queue_row(63, '1, 1'b1);
		wait_idle();

		// Four nodes: short cycle through the highest neighbor, then acyclic, then self loop
		write_node_count(7'd4);
		queue_row(0, 64'hFFFF_0000_0000_000A, 1'b0);
		queue_row(1, 64'h4, 1'b0);
		queue_row(2, 64'h8, 1'b0);
		queue_row(40, rand_word(), 1'b0);
		queue_row(3, 64'h1, 1'b1);
		queue_row(3, '0, 1'b1);
		queue_row(2, 64'h6, 1'b1);
		wait_idle();

		// Random graphs, mostly small; one full-size ring and a few large patches
		phase_no = 0;
		while (queued_rows < ITEM_TARGET) begin
			if (phase_no == 0)
				pick = 7'd127;
			else if (phase_no == 3)
				pick = 7'd64;
			else if (phase_no > 1 && $urandom_range(0, 7) == 0)
				pick = $urandom_range(0, 1) ? 7'd0 : CFG_W'($urandom_range(65, 126));
			else
				pick = CFG_W'($urandom_range(1, 12));
			if (phase_no < 4 || $urandom_range(0, 1) == 1)
				write_node_count(pick);
			n = active_count(count_shadow);
			shape = (phase_no == 0) ? SHAPE_RING : graph_shape_e'($urandom_range(0, 5));
			patch = (n == 0) || (phase_no != 0 && (n > 16 || $urandom_range(0, 3) == 0));

			if (patch) begin
				// fill rows never loaded, then rewrite a few rows
				for (int i = 0; i < n; i++)
					if (!row_loaded[i])
						queue_row(i, rand_word() & rand_word() & rand_word(), 1'b0);
				cnt = $urandom_range(1, 3);
				for (int k = 0; k < cnt; k++)
					queue_row((n == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1),
						($urandom_range(0, 3) == 0) ? '0 : rand_word() & rand_word() & rand_word(),
						k == cnt - 1);
			end else begin
				// build a whole graph of the chosen shape
				for (int i = 0; i < n; i++) begin
					case (shape)
						SHAPE_SPARSE: fresh_rows[i] = rand_word() & rand_word() & rand_word();
						SHAPE_DENSE:  fresh_rows[i] = rand_word() | rand_word();
						SHAPE_RING:   fresh_rows[i] = '0;
						default:      fresh_rows[i] = rand_word() & rand_word() &
							~((64'd2 << i) - 64'd1);
					endcase
					if (shape == SHAPE_DAG_BACK && i + 1 < n)
						fresh_rows[i][i+1] = 1'b1;
					if ($urandom_range(0, 1) == 1)
						fresh_rows[i] |= rand_word() & ~count_mask(n);
				end
				if (shape == SHAPE_DAG_BACK) begin
					lo = $urandom_range(0, n - 1);
					hi = $urandom_range(lo, n - 1);
					fresh_rows[hi][lo] = 1'b1;
				end
				if (shape == SHAPE_SELF_LOOP) begin
					lo = $urandom_range(0, n - 1);
					fresh_rows[lo][lo] = 1'b1;
				end
				if (shape == SHAPE_RING) begin
					shuffle_order(n);
					for (int k = 0; k < n; k++)
						fresh_rows[node_order[k]][node_order[(k + 1) % n]] = 1'b1;
				end

				// rows beyond the count go in as noise; sometimes one of them closes the graph
				tail_row = (n < NODE_SLOTS) && ($urandom_range(0, 3) == 0);
				if (n < NODE_SLOTS)
					repeat ($urandom_range(0, 2))
						queue_row($urandom_range(n, 63), rand_word(), 1'b0);
				shuffle_order(n);
				for (int k = 0; k < n; k++)
					queue_row(node_order[k], fresh_rows[node_order[k]],
						(k == n - 1) && !tail_row);
				if (tail_row)
					queue_row($urandom_range(n, 63), rand_word(), 1'b1);
			end
			wait_idle();
			phase_no++;
		end

		$display("Covered %0d row transfers and %0d searches over %0d graph phases",
			row_transfers, search_count, phase_no);
		$display("Checked %0d results: %0d cycles found, %0d acyclic graphs",
			result_count, cyclic_runs, acyclic_runs);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
